/* hw/rtl/array_deque_shift_store_defines.svh */
// Assertion macros used by the one RTL file that carries checks.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef ARRAY_DEQUE_SHIFT_STORE_DEFINES_SVH
`define ARRAY_DEQUE_SHIFT_STORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ADSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/adss_pkg.sv */
`timescale 1ns / 1ps

package adss_pkg;

  localparam int DEPTH      = 128;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int POS_W      = 8;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GROUP      = 16;
  localparam int NUM_GROUPS = (DEPTH + GROUP - 1) / GROUP;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  typedef enum logic [3:0] {
    FN_PUSH_FRONT = 4'd0,
    FN_PUSH_BACK  = 4'd1,
    FN_POP_FRONT  = 4'd2,
    FN_POP_BACK   = 4'd3,
    FN_INSERT     = 4'd4,
    FN_ERASE      = 4'd5,
    FN_CLEAR      = 4'd6,
    FN_RESIZE     = 4'd7,
    FN_ASSIGN     = 4'd8,
    FN_READ       = 4'd9
  } func_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_RANGE = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    cnt_t      pos;
    cnt_t      lo;
    cnt_t      hi;
    data_t     value;
  } cmd_t;

  function automatic data_t to_data(input logic signed [31:0] v);
    logic signed [63:0] t;
    t = 64'(v);
    return t[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [31:0] from_data(input data_t d);
    logic signed [63:0] t;
    t = 64'($signed(d));
    return t[31:0];
  endfunction

endpackage

/* hw/rtl/adss_if.sv */
`timescale 1ns / 1ps

interface adss_in_if import adss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [3:0]        func;
  logic signed [31:0] value;
  logic [POS_W-1:0]  position;
  logic [7:0]        new_count;

  modport source (output valid, func, value, position, new_count, input ready);
  modport sink   (input valid, func, value, position, new_count, output ready);
endinterface

interface adss_out_if import adss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] read_data;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic [7:0]         entry_count;
  logic               is_empty;
  logic [1:0]         status;

  modport source (output valid, read_data, front_value, back_value, entry_count, is_empty,
                  status, input ready);
  modport sink   (input valid, read_data, front_value, back_value, entry_count, is_empty,
                  status, output ready);
endinterface

/* hw/rtl/adss_cell.sv */
`timescale 1ns / 1ps

module adss_cell import adss_pkg::*; (
  input  logic  clk,
  input  cmd_t  cmd,
  input  cnt_t  idx,
  input  data_t left_data,
  input  data_t right_data,
  output data_t data
);

  data_t data_r;
  data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.kind)
      CMD_HOLD: begin
        data_nxt = data_r;
      end
      CMD_OPEN: begin
        if (idx > cmd.pos) begin
          data_nxt = left_data;
        end else if (idx == cmd.pos) begin
          data_nxt = cmd.value;
        end
      end
      CMD_CLOSE: begin
        if (idx >= cmd.pos) begin
          data_nxt = right_data;
        end
      end
      CMD_RANGE: begin
        if ((idx >= cmd.lo) && (idx < cmd.hi)) begin
          data_nxt = cmd.value;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

/* hw/rtl/adss_pick.sv */
`timescale 1ns / 1ps

module adss_pick import adss_pkg::*; (
  input  logic  clk,
  input  logic  adv,
  input  data_t cell_data [DEPTH],
  input  cnt_t  sel,
  input  logic  sel_en,
  output data_t picked
);

  data_t grp_r   [NUM_GROUPS];
  data_t grp_nxt [NUM_GROUPS];

  always_comb begin
    int i;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        i = g * GROUP + k;
        if (i < DEPTH) begin
          if (sel_en && (sel == CNT_W'(i))) begin
            grp_nxt[g] = grp_nxt[g] | cell_data[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_comb begin
    picked = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      picked = picked | grp_r[g];
    end
  end

endmodule

/* hw/rtl/array_deque_shift_store.sv */
// A result passes through the s1, s2 and output registers after its input transfer.
// One operation per cycle unless stalled; every entry cell shifts in parallel, and the
// read and back lookups pass through a registered two-level OR tree.
// A stalled result stops the whole pipeline until it is taken.
// Reset clears the entry count and all valid flags; entry contents are not cleared.
`timescale 1ns / 1ps
`include "array_deque_shift_store_defines.svh"

module array_deque_shift_store import adss_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  adss_in_if.sink   in_chan,
  adss_out_if.source out_chan
);

  logic    adv;
  logic    in_fire;
  cnt_t    count_r;
  cnt_t    count_nxt;
  cmd_t    cmd_c;
  cmd_t    cmd_apply;
  status_t status_nxt;
  logic    rd_en_nxt;
  cmp_t    pos_x;
  cmp_t    cnt_x;
  cmp_t    ncnt_x;
  logic    is_full;
  logic    is_zero;
  data_t   val;

  data_t   cell_data [DEPTH];

  logic    s1_valid_r;
  status_t s1_status_r;
  logic    s1_rd_en_r;
  cnt_t    s1_pos_r;

  logic    s2_valid_r;
  status_t s2_status_r;
  cnt_t    s2_count_r;
  data_t   s2_front_r;

  data_t   rd_pick;
  data_t   bk_pick;

  logic    out_valid_r;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;
  assign in_fire       = in_chan.valid && adv;

  assign pos_x   = CMP_W'(in_chan.position);
  assign cnt_x   = CMP_W'(count_r);
  assign ncnt_x  = CMP_W'(in_chan.new_count);
  assign is_full = (count_r == CNT_W'(DEPTH));
  assign is_zero = (count_r == '0);
  assign val     = to_data(in_chan.value);

  always_comb begin
    cmd_c.kind  = CMD_HOLD;
    cmd_c.pos   = '0;
    cmd_c.lo    = '0;
    cmd_c.hi    = '0;
    cmd_c.value = val;
    status_nxt  = ST_OK;
    rd_en_nxt   = 1'b0;
    count_nxt   = count_r;
    unique case (in_chan.func)
      FN_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd_c.kind = CMD_OPEN;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      FN_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd_c.kind = CMD_OPEN;
          cmd_c.pos  = count_r;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      FN_POP_FRONT: begin
        if (is_zero) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd_c.kind = CMD_CLOSE;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      FN_POP_BACK: begin
        if (is_zero) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FN_INSERT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else if (pos_x > cnt_x) begin
          status_nxt = ST_BAD;
        end else begin
          cmd_c.kind = CMD_OPEN;
          cmd_c.pos  = CNT_W'(pos_x);
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      FN_ERASE: begin
        if (is_zero) begin
          status_nxt = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_nxt = ST_BAD;
        end else begin
          cmd_c.kind = CMD_CLOSE;
          cmd_c.pos  = CNT_W'(pos_x);
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      FN_CLEAR: begin
        count_nxt = '0;
      end
      FN_RESIZE: begin
        if (ncnt_x > CMP_W'(DEPTH)) begin
          status_nxt = ST_BAD;
        end else begin
          cmd_c.kind  = CMD_RANGE;
          cmd_c.lo    = count_r;
          cmd_c.hi    = CNT_W'(ncnt_x);
          cmd_c.value = '0;
          count_nxt   = CNT_W'(ncnt_x);
        end
      end
      FN_ASSIGN: begin
        if (ncnt_x > cnt_x) begin
          status_nxt = ST_BAD;
        end else begin
          cmd_c.kind = CMD_RANGE;
          cmd_c.hi   = CNT_W'(ncnt_x);
          count_nxt  = CNT_W'(ncnt_x);
        end
      end
      FN_READ: begin
        if (pos_x >= cnt_x) begin
          status_nxt = ST_BAD;
        end else begin
          rd_en_nxt = 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_comb begin
    cmd_apply = cmd_c;
    if (!in_fire) begin
      cmd_apply.kind = CMD_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t left_d;
    data_t right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end
    adss_cell u_cell (
      .clk        (clk),
      .cmd        (cmd_apply),
      .idx        (CNT_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i])
    );
  end

  adss_pick u_rd_pick (
    .clk       (clk),
    .adv       (adv),
    .cell_data (cell_data),
    .sel       (s1_pos_r),
    .sel_en    (s1_valid_r && s1_rd_en_r),
    .picked    (rd_pick)
  );

  adss_pick u_bk_pick (
    .clk       (clk),
    .adv       (adv),
    .cell_data (cell_data),
    .sel       (count_r - CNT_W'(1)),
    .sel_en    (!is_zero),
    .picked    (bk_pick)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      if (adv) begin
        s1_valid_r  <= in_fire;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_status_r <= status_nxt;
      s1_rd_en_r  <= rd_en_nxt;
      s1_pos_r    <= CNT_W'(pos_x);
      s2_status_r <= s1_status_r;
      s2_count_r  <= count_r;
      s2_front_r  <= is_zero ? '0 : cell_data[0];
      out_chan.read_data   <= from_data(rd_pick);
      out_chan.front_value <= from_data(s2_front_r);
      out_chan.back_value  <= from_data(bk_pick);
      out_chan.entry_count <= 8'(s2_count_r);
      out_chan.is_empty    <= (s2_count_r == '0);
      out_chan.status      <= s2_status_r;
    end
  end

  assign out_chan.valid = out_valid_r;

  `ADSS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count exceeds depth")
  `ADSS_ASSERT_NXT(a_err_keeps_count, in_fire && (status_nxt != ST_OK), count_r == $past(count_r), "failed operation changed count")
  `ADSS_ASSERT_NXT(a_clear_empties, in_fire && (in_chan.func == FN_CLEAR), count_r == '0, "clear left entries")
  `ADSS_ASSERT_NXT(a_pipe_moves, s1_valid_r && adv, s2_valid_r, "pipeline dropped an operation")

endmodule
